>>> rtl/jabd_pkg.sv
// ----------------------------------------------------------------------------
// JPEG arithmetic block debinarizer package
// Shared types, codes and fixed constants of the context-modelling decoder.
// ----------------------------------------------------------------------------
package jabd_pkg;

  // Conditioning tables and magnitude category limits.
  localparam int TABLES        = 4;
  localparam int DC_CATEGORIES = 15;
  localparam int AC_CATEGORIES = 14;

  // Context numbering anchors.
  localparam int DC_X_BASE   = 20;
  localparam int AC_SIGN_CTX = 189;
  localparam int AC_X_BASE   = 190;

  // Initial magnitude masks when category coding begins.
  localparam logic [16:0] DC_MASK_INIT = 17'd2;
  localparam logic [16:0] AC_MASK_INIT = 17'd4;

  typedef enum logic [1:0] {
    KIND_RESTART  = 2'd0,
    KIND_START    = 2'd1,
    KIND_DECISION = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_SCAN_START   = 3'd0,
    REG_SCAN_STOP    = 3'd1,
    REG_POINT_SHIFT  = 3'd2,
    REG_DIFF_MODE    = 3'd3,
    REG_DC_LOWER     = 3'd4,
    REG_DC_UPPER     = 3'd5,
    REG_AC_BAND      = 3'd6,
    REG_TABLE_SELECT = 3'd7
  } reg_index_t;

  typedef enum logic [12:0] {
    PH_IDLE    = 13'b0000000000001,
    PH_DC_S0   = 13'b0000000000010,
    PH_DC_SS   = 13'b0000000000100,
    PH_DC_SPN  = 13'b0000000001000,
    PH_DC_X    = 13'b0000000010000,
    PH_DC_M    = 13'b0000000100000,
    PH_AC_SE   = 13'b0000001000000,
    PH_AC_S0   = 13'b0000010000000,
    PH_AC_SIGN = 13'b0000100000000,
    PH_AC_SP1  = 13'b0001000000000,
    PH_AC_SP2  = 13'b0010000000000,
    PH_AC_X    = 13'b0100000000000,
    PH_AC_M    = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    logic [5:0]  scan_start;
    logic [5:0]  scan_stop;
    logic [3:0]  point_shift;
    logic        differential_mode;
    logic [15:0] dc_lower_thresholds;
    logic [15:0] dc_upper_thresholds;
    logic [23:0] ac_band_limits;
    logic [15:0] table_select;
  } cfg_t;

  typedef struct packed {
    logic               need_decision;
    logic               context_is_ac;
    logic [1:0]         context_table;
    logic [7:0]         context_offset;
    logic               coef_valid;
    logic [5:0]         coef_position;
    logic signed [16:0] coef_value;
    logic               block_done;
    logic               sync_error;
  } res_t;

  function automatic logic [1:0] clamp_table(input logic [1:0] t);
    logic [1:0] r;
    r = (32'(t) >= TABLES) ? 2'(TABLES - 1) : t;
    return r;
  endfunction

endpackage

>>> rtl/jabd_cfg.sv
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the scan and conditioning registers written over the config channel.
// ----------------------------------------------------------------------------
module jabd_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_data,
  output jabd_pkg::cfg_t   cfg
);

  jabd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_start          <= 6'd0;
      cfg_r.scan_stop           <= 6'd63;
      cfg_r.point_shift         <= 4'd0;
      cfg_r.differential_mode   <= 1'b0;
      cfg_r.dc_lower_thresholds <= 16'h0000;
      cfg_r.dc_upper_thresholds <= 16'h1111;
      cfg_r.ac_band_limits      <= 24'h145145;
      cfg_r.table_select        <= 16'h0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        jabd_pkg::REG_SCAN_START:   cfg_r.scan_start          <= cfg_data[5:0];
        jabd_pkg::REG_SCAN_STOP:    cfg_r.scan_stop           <= cfg_data[5:0];
        jabd_pkg::REG_POINT_SHIFT:  cfg_r.point_shift         <= cfg_data[3:0];
        jabd_pkg::REG_DIFF_MODE:    cfg_r.differential_mode   <= cfg_data[0];
        jabd_pkg::REG_DC_LOWER:     cfg_r.dc_lower_thresholds <= cfg_data[15:0];
        jabd_pkg::REG_DC_UPPER:     cfg_r.dc_upper_thresholds <= cfg_data[15:0];
        jabd_pkg::REG_AC_BAND:      cfg_r.ac_band_limits      <= cfg_data;
        jabd_pkg::REG_TABLE_SELECT: cfg_r.table_select        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/jabd_ctx.sv
// ----------------------------------------------------------------------------
// Context modeller
// Decoding state, DC predictors and the next-context selection for one item.
// ----------------------------------------------------------------------------
module jabd_ctx #(
  parameter int COMPONENTS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  jabd_pkg::cfg_t   cfg,
  input  logic             in_push,
  input  logic [1:0]       in_kind,
  input  logic [1:0]       in_comp,
  input  logic             in_bit,
  output jabd_pkg::res_t   res_nxt
);

  localparam int CW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam logic [4:0] DC_LIMIT   = 5'(jabd_pkg::DC_CATEGORIES);
  localparam logic [4:0] AC_LIMIT   = 5'(jabd_pkg::AC_CATEGORIES);
  localparam logic [7:0] DC_X_OFS   = 8'(jabd_pkg::DC_X_BASE);
  localparam logic [7:0] DC_M_OFS   = 8'(jabd_pkg::DC_X_BASE + jabd_pkg::DC_CATEGORIES);
  localparam logic [7:0] AC_XL_OFS  = 8'(jabd_pkg::AC_X_BASE);
  localparam logic [7:0] AC_XH_OFS  = 8'(jabd_pkg::AC_X_BASE + 2 * jabd_pkg::AC_CATEGORIES);
  localparam logic [7:0] AC_ML_OFS  = 8'(jabd_pkg::AC_X_BASE + jabd_pkg::AC_CATEGORIES);
  localparam logic [7:0] AC_MH_OFS  = 8'(jabd_pkg::AC_X_BASE + 3 * jabd_pkg::AC_CATEGORIES);
  localparam logic [7:0] AC_SIGN_OFS = 8'(jabd_pkg::AC_SIGN_CTX);

  jabd_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [3:0]  cat_r, cat_nxt;
  logic [16:0] mask_r, mask_nxt;
  logic [15:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic [2:0]  class_r, class_nxt;
  logic [16:0] pred_r  [COMPONENTS];
  logic [16:0] ldiff_r [COMPONENTS];

  logic        fin_dc, fin_ac, fin_zero, start_enter, done, err;
  logic [15:0] fin_mag;
  logic [4:0]  cat_step;
  logic [15:0] mag_half, mag_ref;
  logic [1:0]  comp_clamp;

  // Start-of-block DC classification from the last difference.
  logic [1:0]  start_tab;
  logic [3:0]  thr_l, thr_u;
  logic [16:0] start_diff, start_abs, lim_l, lim_u;
  logic [2:0]  start_class;

  // Coefficient reconstruction.
  logic [16:0] sv1, sv, dc_diff, pred_cur, pred_new, coef_base, coef_val;
  logic        enter;
  logic [6:0]  enter_k;

  // Result context selection.
  logic [1:0]  dc_tab, ac_tab;
  logic [4:0]  band_lsb;
  logic [5:0]  band_kx;
  logic        high_band;
  logic [5:0]  pos_m1;
  logic [7:0]  ac_base, class_base, cat_ofs, offset;
  logic        is_dc_phase;

  assign comp_clamp = (32'(in_comp) >= COMPONENTS) ? 2'(COMPONENTS - 1) : in_comp;

  assign start_tab  = jabd_pkg::clamp_table(cfg.table_select[{comp_clamp, 2'b00} +: 2]);
  assign thr_l      = cfg.dc_lower_thresholds[{start_tab, 2'b00} +: 4];
  assign thr_u      = cfg.dc_upper_thresholds[{start_tab, 2'b00} +: 4];
  assign start_diff = ldiff_r[comp_clamp[CW-1:0]];
  assign start_abs  = start_diff[16] ? 17'(~start_diff + 17'd1) : start_diff;
  assign lim_l      = 17'((17'd1 << thr_l) >> 1);
  assign lim_u      = 17'(17'd1 << thr_u);

  always_comb begin
    if (start_abs <= lim_l) begin
      start_class = 3'd0;
    end else if (start_abs <= lim_u) begin
      start_class = start_diff[16] ? 3'd2 : 3'd1;
    end else begin
      start_class = start_diff[16] ? 3'd4 : 3'd3;
    end
  end

  assign cat_step = {1'b0, cat_r} + 5'd1;
  assign mag_half = mask_r[16:1];
  assign mag_ref  = in_bit ? (mag_r | mask_r[15:0]) : mag_r;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    cat_nxt     = cat_r;
    mask_nxt    = mask_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    comp_nxt    = comp_r;
    class_nxt   = class_r;
    fin_dc      = 1'b0;
    fin_ac      = 1'b0;
    fin_zero    = 1'b0;
    fin_mag     = '0;
    start_enter = 1'b0;
    done        = 1'b0;
    err         = 1'b0;
    enter       = 1'b0;
    enter_k     = '0;
    if (in_push) begin
      case (in_kind)
        jabd_pkg::KIND_RESTART: phase_nxt = jabd_pkg::PH_IDLE;
        jabd_pkg::KIND_START: begin
          comp_nxt = comp_clamp;
          if (cfg.scan_start == 6'd0) begin
            class_nxt = start_class;
            phase_nxt = jabd_pkg::PH_DC_S0;
          end else begin
            start_enter = 1'b1;
          end
        end
        jabd_pkg::KIND_DECISION: begin
          case (phase_r)
            jabd_pkg::PH_DC_S0: begin
              if (in_bit) begin
                phase_nxt = jabd_pkg::PH_DC_SS;
              end else begin
                fin_dc   = 1'b1;
                fin_zero = 1'b1;
              end
            end
            jabd_pkg::PH_DC_SS: begin
              neg_nxt   = in_bit;
              phase_nxt = jabd_pkg::PH_DC_SPN;
            end
            jabd_pkg::PH_DC_SPN: begin
              if (in_bit) begin
                cat_nxt   = 4'd0;
                mask_nxt  = jabd_pkg::DC_MASK_INIT;
                phase_nxt = jabd_pkg::PH_DC_X;
              end else begin
                fin_dc = 1'b1;
              end
            end
            jabd_pkg::PH_DC_X, jabd_pkg::PH_AC_X: begin
              if (in_bit) begin
                mask_nxt = 17'(mask_r << 1);
                cat_nxt  = cat_step[3:0];
                if (cat_step >= ((phase_r == jabd_pkg::PH_DC_X) ? DC_LIMIT : AC_LIMIT)) begin
                  phase_nxt = jabd_pkg::PH_IDLE;
                  done      = 1'b1;
                  err       = 1'b1;
                end
              end else begin
                mag_nxt  = mag_half;
                mask_nxt = {2'b00, mag_half[15:1]};
                if (mag_half[15:1] != 15'd0) begin
                  phase_nxt = (phase_r == jabd_pkg::PH_DC_X) ? jabd_pkg::PH_DC_M
                                                              : jabd_pkg::PH_AC_M;
                end else begin
                  fin_mag = mag_half;
                  fin_dc  = (phase_r == jabd_pkg::PH_DC_X);
                  fin_ac  = (phase_r == jabd_pkg::PH_AC_X);
                end
              end
            end
            jabd_pkg::PH_DC_M, jabd_pkg::PH_AC_M: begin
              mag_nxt  = mag_ref;
              mask_nxt = {1'b0, mask_r[16:1]};
              if (mask_r[16:1] == 16'd0) begin
                fin_mag = mag_ref;
                fin_dc  = (phase_r == jabd_pkg::PH_DC_M);
                fin_ac  = (phase_r == jabd_pkg::PH_AC_M);
              end
            end
            jabd_pkg::PH_AC_SE: begin
              if (in_bit) begin
                phase_nxt = jabd_pkg::PH_IDLE;
                done      = 1'b1;
              end else begin
                phase_nxt = jabd_pkg::PH_AC_S0;
              end
            end
            jabd_pkg::PH_AC_S0: begin
              if (in_bit) begin
                phase_nxt = jabd_pkg::PH_AC_SIGN;
              end else if (({1'b0, pos_r} + 7'd1) > {1'b0, cfg.scan_stop}) begin
                // A zero run may not step past the end of the scan (scan_stop).
                phase_nxt = jabd_pkg::PH_IDLE;
                done      = 1'b1;
                err       = 1'b1;
              end else begin
                pos_nxt = pos_r + 6'd1;
              end
            end
            jabd_pkg::PH_AC_SIGN: begin
              neg_nxt   = in_bit;
              phase_nxt = jabd_pkg::PH_AC_SP1;
            end
            jabd_pkg::PH_AC_SP1: begin
              if (in_bit) begin
                phase_nxt = jabd_pkg::PH_AC_SP2;
              end else begin
                fin_ac = 1'b1;
              end
            end
            jabd_pkg::PH_AC_SP2: begin
              if (in_bit) begin
                cat_nxt   = 4'd0;
                mask_nxt  = jabd_pkg::AC_MASK_INIT;
                phase_nxt = jabd_pkg::PH_AC_X;
              end else begin
                fin_ac  = 1'b1;
                fin_mag = 16'd1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      // Move on to the next AC position, or close the block past scan_stop.
      enter   = start_enter | fin_dc | fin_ac;
      enter_k = start_enter ? {1'b0, cfg.scan_start} :
                fin_dc      ? 7'd1 : ({1'b0, pos_r} + 7'd1);
      if (enter) begin
        if (enter_k <= {1'b0, cfg.scan_stop}) begin
          phase_nxt = jabd_pkg::PH_AC_SE;
          pos_nxt   = enter_k[5:0];
        end else begin
          phase_nxt = jabd_pkg::PH_IDLE;
          done      = 1'b1;
        end
      end
    end
  end

  assign sv1       = {1'b0, fin_mag} + 17'd1;
  assign sv        = neg_r ? 17'(~sv1 + 17'd1) : sv1;
  assign dc_diff   = fin_zero ? 17'd0 : sv;
  assign pred_cur  = pred_r[comp_r[CW-1:0]];
  assign pred_new  = cfg.differential_mode ? dc_diff : 17'(pred_cur + dc_diff);
  assign coef_base = fin_dc ? pred_new : sv;
  assign coef_val  = 17'(coef_base << cfg.point_shift);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jabd_pkg::PH_IDLE;
      pos_r   <= 6'd0;
      cat_r   <= 4'd0;
      mask_r  <= 17'd0;
      mag_r   <= 16'd0;
      neg_r   <= 1'b0;
      comp_r  <= 2'd0;
      class_r <= 3'd0;
      for (int i = 0; i < COMPONENTS; i++) begin
        pred_r[i]  <= 17'd0;
        ldiff_r[i] <= 17'd0;
      end
    end else if (in_push) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cat_r   <= cat_nxt;
      mask_r  <= mask_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      comp_r  <= comp_nxt;
      class_r <= class_nxt;
      if (in_kind == jabd_pkg::KIND_RESTART) begin
        for (int i = 0; i < COMPONENTS; i++) begin
          pred_r[i]  <= 17'd0;
          ldiff_r[i] <= 17'd0;
        end
      end else if (fin_dc) begin
        pred_r[comp_r[CW-1:0]]  <= pred_new;
        ldiff_r[comp_r[CW-1:0]] <= dc_diff;
      end
    end
  end

  // Context of the next request, taken from the updated state.
  assign dc_tab    = jabd_pkg::clamp_table(cfg.table_select[{comp_nxt, 2'b00} +: 2]);
  assign ac_tab    = jabd_pkg::clamp_table(cfg.table_select[{comp_nxt, 2'b10} +: 2]);
  assign band_lsb  = 5'({ac_tab, 2'b00}) + 5'({ac_tab, 1'b0});
  assign band_kx   = cfg.ac_band_limits[band_lsb +: 6];
  assign high_band = pos_nxt > band_kx;
  assign pos_m1    = pos_nxt - 6'd1;
  assign ac_base   = 8'({pos_m1, 1'b0}) + 8'(pos_m1);
  assign class_base = {3'b000, class_nxt, 2'b00};
  assign cat_ofs   = {4'd0, cat_nxt};
  assign is_dc_phase = phase_nxt inside {jabd_pkg::PH_DC_S0, jabd_pkg::PH_DC_SS,
                                         jabd_pkg::PH_DC_SPN, jabd_pkg::PH_DC_X,
                                         jabd_pkg::PH_DC_M};

  always_comb begin
    case (phase_nxt)
      jabd_pkg::PH_DC_S0:   offset = class_base;
      jabd_pkg::PH_DC_SS:   offset = class_base + 8'd1;
      jabd_pkg::PH_DC_SPN:  offset = class_base + 8'd2 + {7'd0, neg_nxt};
      jabd_pkg::PH_DC_X:    offset = DC_X_OFS + cat_ofs;
      jabd_pkg::PH_DC_M:    offset = DC_M_OFS + cat_ofs;
      jabd_pkg::PH_AC_SE:   offset = ac_base;
      jabd_pkg::PH_AC_S0:   offset = ac_base + 8'd1;
      jabd_pkg::PH_AC_SIGN: offset = AC_SIGN_OFS;
      jabd_pkg::PH_AC_SP1,
      jabd_pkg::PH_AC_SP2:  offset = ac_base + 8'd2;
      jabd_pkg::PH_AC_X:    offset = (high_band ? AC_XH_OFS : AC_XL_OFS) + cat_ofs;
      jabd_pkg::PH_AC_M:    offset = (high_band ? AC_MH_OFS : AC_ML_OFS) + cat_ofs;
      default:              offset = 8'd0;
    endcase
  end

  always_comb begin
    res_nxt.need_decision  = (phase_nxt != jabd_pkg::PH_IDLE);
    res_nxt.context_is_ac  = res_nxt.need_decision && !is_dc_phase;
    res_nxt.context_table  = !res_nxt.need_decision ? 2'd0 : (is_dc_phase ? dc_tab : ac_tab);
    res_nxt.context_offset = offset;
    res_nxt.coef_valid     = fin_dc | fin_ac;
    res_nxt.coef_position  = fin_ac ? pos_r : 6'd0;
    res_nxt.coef_value     = (fin_dc | fin_ac) ? coef_val : 17'd0;
    res_nxt.block_done     = done;
    res_nxt.sync_error     = err;
  end

endmodule

>>> rtl/jabd_obuf.sv
// ----------------------------------------------------------------------------
// Result output stage
// Result register plus one skid entry, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module jabd_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jabd_pkg::res_t   push_res,
  output logic             push_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output jabd_pkg::res_t   out_res
);

  logic           main_valid_r, skid_valid_r;
  jabd_pkg::res_t main_r, skid_r;
  logic           take;

  assign take       = main_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_res    = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push && main_valid_r && !take) begin
      skid_valid_r <= 1'b1;
    end else if (push) begin
      main_valid_r <= 1'b1;
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (push && main_valid_r && !take) begin
      skid_r <= push_res;
    end else if (push) begin
      main_r <= push_res;
    end
  end

endmodule

>>> rtl/jpeg_arith_block_debinarizer.sv
// ----------------------------------------------------------------------------
// JPEG arithmetic block debinarizer
// Context modelling for arithmetic-coded DC/AC coefficient decoding.
// ----------------------------------------------------------------------------
// Channel  Direction  Transfer carries
// in_      input      kind, component, decision bit
// out_     output     next context request, coefficient, block status
// cfg_     input      register index and write data
//
// One item is taken per cycle while the skid entry is empty, and its result
// is registered. The rate is set by the state update of the context modeller,
// which every decision depends on. A result register and one skid entry let
// input continue while a result waits. Synchronous reset clears the state,
// the DC predictors and restores the register defaults.
// ----------------------------------------------------------------------------
module jpeg_arith_block_debinarizer #(
  parameter int COMPONENTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] component, [2] decision_bit, [7:3] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] context_is_ac, [2:1] context_table, [10:3] context_offset,
  // [16:11] coef_position, [33:17] coef_value, [34] sync_error, [39:35] zero
  output logic [39:0] out_tdata,
  output logic [1:0]  out_tuser,  // [0] need_decision, [1] coef_valid
  output logic        out_tlast,  // block_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  jabd_pkg::cfg_t cfg;
  jabd_pkg::res_t res_nxt, res_out;
  logic           push;

  assign push = in_tvalid && in_tready;

  jabd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jabd_ctx #(
    .COMPONENTS (COMPONENTS)
  ) u_ctx (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_push (push),
    .in_kind (in_tuser),
    .in_comp (in_tdata[1:0]),
    .in_bit  (in_tdata[2]),
    .res_nxt (res_nxt)
  );

  jabd_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_res   (res_nxt),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res_out)
  );

  assign out_tdata = {5'd0, res_out.sync_error, res_out.coef_value, res_out.coef_position,
                      res_out.context_offset, res_out.context_table, res_out.context_is_ac};
  assign out_tuser = {res_out.coef_valid, res_out.need_decision};
  assign out_tlast = res_out.block_done;

endmodule

>>> rtl/jabd_checker.sv
// ----------------------------------------------------------------------------
// JPEG arithmetic block debinarizer checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module jabd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result must hold until its transfer.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  a_err_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> out_tlast)
    else $error("sync error without block end");

  a_done_no_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser[0])
    else $error("block end still requests a decision");

  a_idle_context_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[10:0] == 11'd0)
    else $error("context fields set without a request");

  a_no_coef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[33:11] == 23'd0)
    else $error("coefficient fields set without a coefficient");

endmodule

bind jpeg_arith_block_debinarizer jabd_checker u_jabd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> test/tb_jpeg_arith_block_debinarizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the JPEG arithmetic block debinarizer
// Drives start, restart and decision items into the context modeller and
// predicts each result: the next context request, any decoded coefficient,
// and the end-of-block and sync-error flags. Directed checks cover register
// extremes, DC and AC decoding, empty blocks, zero runs past the scan end,
// abandoned blocks and register writes in the middle of a block. A random
// part then plays well-formed blocks with some noise under random stalls.
// ----------------------------------------------------------------------------
module tb_jpeg_arith_block_debinarizer;

  localparam int          COMP_COUNT  = 4;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  localparam jabd_pkg::cfg_t CFG_DEFAULT = '{
    scan_start: 6'd0, scan_stop: 6'd63, point_shift: 4'd0, differential_mode: 1'b0,
    dc_lower_thresholds: 16'h0000, dc_upper_thresholds: 16'h1111,
    ac_band_limits: 24'd1331525, table_select: 16'h0000
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  jpeg_arith_block_debinarizer #(.COMPONENTS(COMP_COUNT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shared run control.
  jabd_pkg::res_t expected_results[$];
  int   err_count = 0;
  int   result_count = 0;
  int   cycle_count = 0;
  int   idle_pct = 0;
  int   sink_hold = 0;
  int   blocks_started = 0;
  logic runaway = 1'b0;

  // Decoder state as the block should hold it.
  jabd_pkg::cfg_t   regs = CFG_DEFAULT;
  logic [16:0]      dc_pred[COMP_COUNT] = '{default: '0};
  logic [16:0]      dc_last_diff[COMP_COUNT] = '{default: '0};
  jabd_pkg::phase_t ph = jabd_pkg::PH_IDLE;
  int               pos = 0;
  int               cat = 0;
  logic [16:0]      mmask = '0;
  logic [16:0]      mag = '0;
  logic             neg = 1'b0;
  logic [1:0]       comp_q = '0;
  logic [2:0]       cls = '0;
  jabd_pkg::res_t   r_work;

  function automatic logic [1:0] dc_tab();
    logic [1:0] t;
    t = regs.table_select[4*comp_q +: 2];
    if (int'(t) >= jabd_pkg::TABLES) t = 2'(jabd_pkg::TABLES - 1);
    return t;
  endfunction

  function automatic logic [1:0] ac_tab();
    logic [1:0] t;
    t = regs.table_select[4*comp_q + 2 +: 2];
    if (int'(t) >= jabd_pkg::TABLES) t = 2'(jabd_pkg::TABLES - 1);
    return t;
  endfunction

  // Five-class L/U conditioning of the previous DC difference.
  function automatic logic [2:0] dc_class_of(logic [16:0] d);
    logic [1:0] t;
    int lo, hi, a;
    t  = dc_tab();
    lo = regs.dc_lower_thresholds[4*t +: 4];
    hi = regs.dc_upper_thresholds[4*t +: 4];
    a  = d[16] ? (32'h20000 - int'(d)) : int'(d);
    if (a <= ((1 << lo) >> 1)) return 3'd0;
    if (a <= (1 << hi)) return d[16] ? 3'd2 : 3'd1;
    return d[16] ? 3'd4 : 3'd3;
  endfunction

  function automatic void open_ac(int k);
    if (k <= int'(regs.scan_stop)) begin
      ph  = jabd_pkg::PH_AC_SE;
      pos = k;
    end else begin
      ph = jabd_pkg::PH_IDLE;
      r_work.block_done = 1'b1;
    end
  endfunction

  function automatic void abort_block();
    ph = jabd_pkg::PH_IDLE;
    r_work.block_done = 1'b1;
    r_work.sync_error = 1'b1;
  endfunction

  function automatic logic [16:0] signed_mag(logic [16:0] sz);
    logic [16:0] v;
    v = sz + 17'd1;
    return neg ? -v : v;
  endfunction

  function automatic void close_dc(logic [16:0] diff);
    dc_last_diff[comp_q] = diff;
    dc_pred[comp_q] = regs.differential_mode ? diff : dc_pred[comp_q] + diff;
    r_work.coef_valid    = 1'b1;
    r_work.coef_position = '0;
    r_work.coef_value    = dc_pred[comp_q] << regs.point_shift;
    open_ac(1);
  endfunction

  function automatic void close_ac(logic [16:0] sz);
    logic [16:0] v;
    v = signed_mag(sz) << regs.point_shift;
    r_work.coef_valid    = 1'b1;
    r_work.coef_position = 6'(pos);
    r_work.coef_value    = v;
    open_ac(pos + 1);
  endfunction

  function automatic void category_step(logic b, int limit, jabd_pkg::phase_t next_ph,
                                        logic is_dc);
    if (b) begin
      mmask = mmask << 1;
      cat++;
      if (cat >= limit) abort_block();
      return;
    end
    mag   = mmask >> 1;
    mmask = mag >> 1;
    if (mmask != 0) ph = next_ph;
    else if (is_dc) close_dc(signed_mag(mag));
    else close_ac(mag);
  endfunction

  function automatic void refine_step(logic b, logic is_dc);
    if (b) mag = mag | mmask;
    mmask = mmask >> 1;
    if (mmask == 0) begin
      if (is_dc) close_dc(signed_mag(mag));
      else close_ac(mag);
    end
  endfunction

  function automatic void apply_decision(logic b);
    case (ph)
      jabd_pkg::PH_DC_S0: if (b) ph = jabd_pkg::PH_DC_SS; else close_dc('0);
      jabd_pkg::PH_DC_SS: begin
        neg = b;
        ph  = jabd_pkg::PH_DC_SPN;
      end
      jabd_pkg::PH_DC_SPN: begin
        if (b) begin
          cat   = 0;
          mmask = jabd_pkg::DC_MASK_INIT;
          ph    = jabd_pkg::PH_DC_X;
        end else begin
          close_dc(signed_mag('0));
        end
      end
      jabd_pkg::PH_DC_X:
        category_step(b, jabd_pkg::DC_CATEGORIES, jabd_pkg::PH_DC_M, 1'b1);
      jabd_pkg::PH_DC_M: refine_step(b, 1'b1);
      jabd_pkg::PH_AC_SE: begin
        if (b) begin
          ph = jabd_pkg::PH_IDLE;
          r_work.block_done = 1'b1;
        end else begin
          ph = jabd_pkg::PH_AC_S0;
        end
      end
      jabd_pkg::PH_AC_S0: begin
        if (b) ph = jabd_pkg::PH_AC_SIGN;
        else if (pos + 1 > int'(regs.scan_stop)) abort_block();
        else pos++;
      end
      jabd_pkg::PH_AC_SIGN: begin
        neg = b;
        ph  = jabd_pkg::PH_AC_SP1;
      end
      jabd_pkg::PH_AC_SP1: if (b) ph = jabd_pkg::PH_AC_SP2; else close_ac('0);
      jabd_pkg::PH_AC_SP2: begin
        if (b) begin
          cat   = 0;
          mmask = jabd_pkg::AC_MASK_INIT;
          ph    = jabd_pkg::PH_AC_X;
        end else begin
          close_ac(17'd1);
        end
      end
      jabd_pkg::PH_AC_X:
        category_step(b, jabd_pkg::AC_CATEGORIES, jabd_pkg::PH_AC_M, 1'b0);
      jabd_pkg::PH_AC_M: refine_step(b, 1'b0);
      default: ;
    endcase
  endfunction

  // Advances the decoder state by one item and returns the result it causes.
  function automatic jabd_pkg::res_t predict_item(logic [1:0] k, logic [1:0] comp, logic b);
    int off, base;
    logic [1:0] t;
    logic upper_band;
    r_work = '0;
    off = 0;
    case (k)
      jabd_pkg::KIND_RESTART: begin
        for (int i = 0; i < COMP_COUNT; i++) begin
          dc_pred[i] = '0;
          dc_last_diff[i] = '0;
        end
        ph = jabd_pkg::PH_IDLE;
      end
      jabd_pkg::KIND_START: begin
        comp_q = (int'(comp) >= COMP_COUNT) ? 2'(COMP_COUNT - 1) : comp;
        if (regs.scan_start == 0) begin
          cls = dc_class_of(dc_last_diff[comp_q]);
          ph  = jabd_pkg::PH_DC_S0;
        end else begin
          open_ac(int'(regs.scan_start));
        end
      end
      jabd_pkg::KIND_DECISION: apply_decision(b);
      default: ;
    endcase

    case (ph)
      jabd_pkg::PH_IDLE: ;
      jabd_pkg::PH_DC_S0, jabd_pkg::PH_DC_SS, jabd_pkg::PH_DC_SPN, jabd_pkg::PH_DC_X,
      jabd_pkg::PH_DC_M: begin
        r_work.context_table = dc_tab();
        case (ph)
          jabd_pkg::PH_DC_X:   off = jabd_pkg::DC_X_BASE + cat;
          jabd_pkg::PH_DC_M:   off = jabd_pkg::DC_X_BASE + jabd_pkg::DC_CATEGORIES + cat;
          jabd_pkg::PH_DC_SPN: off = 4 * cls + 2 + neg;
          jabd_pkg::PH_DC_SS:  off = 4 * cls + 1;
          default:             off = 4 * cls;
        endcase
      end
      default: begin
        t = ac_tab();
        base = 3 * (pos - 1);
        upper_band = pos > int'(regs.ac_band_limits[6*t +: 6]);
        r_work.context_is_ac = 1'b1;
        r_work.context_table = t;
        case (ph)
          jabd_pkg::PH_AC_SE:   off = base;
          jabd_pkg::PH_AC_S0:   off = base + 1;
          jabd_pkg::PH_AC_SIGN: off = jabd_pkg::AC_SIGN_CTX;
          jabd_pkg::PH_AC_X:
            off = jabd_pkg::AC_X_BASE + (upper_band ? 2 * jabd_pkg::AC_CATEGORIES : 0) + cat;
          jabd_pkg::PH_AC_M:
            off = jabd_pkg::AC_X_BASE + (upper_band ? 3 : 1) * jabd_pkg::AC_CATEGORIES + cat;
          default:              off = base + 2;
        endcase
      end
    endcase
    r_work.need_decision  = (ph != jabd_pkg::PH_IDLE);
    r_work.context_offset = 8'(off);
    return r_work;
  endfunction

  // Decision bits steered by the pending request so blocks run deep; a runaway
  // block keeps answering "larger" until a category limit aborts it.
  function automatic logic pick_bit();
    case (ph)
      jabd_pkg::PH_AC_SE: return runaway ? 1'b0 : ($urandom_range(0, 3) == 0);
      jabd_pkg::PH_DC_S0, jabd_pkg::PH_DC_SPN, jabd_pkg::PH_AC_S0, jabd_pkg::PH_AC_SP1,
      jabd_pkg::PH_AC_SP2:
        return runaway ? 1'b1 : 1'($urandom_range(0, 1));
      jabd_pkg::PH_DC_X, jabd_pkg::PH_AC_X:
        return runaway ? 1'b1 : ($urandom_range(0, 2) == 0);
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d, %s: got %0d, expected %0d",
                                result_count, name, got, want));
  endtask

  task automatic send_item(logic [1:0] k, logic [1:0] comp, logic b);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {5'b00000, b, comp};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_item(k, comp, b));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Registers are written only once every pending result has come back.
  task automatic load_config(jabd_pkg::cfg_t c);
    jabd_pkg::reg_index_t idx;
    logic [23:0] v;
    drain_results();
    idx = idx.first();
    do begin
      case (idx)
        jabd_pkg::REG_SCAN_START:  v = 24'(c.scan_start);
        jabd_pkg::REG_SCAN_STOP:   v = 24'(c.scan_stop);
        jabd_pkg::REG_POINT_SHIFT: v = 24'(c.point_shift);
        jabd_pkg::REG_DIFF_MODE:   v = 24'(c.differential_mode);
        jabd_pkg::REG_DC_LOWER:    v = 24'(c.dc_lower_thresholds);
        jabd_pkg::REG_DC_UPPER:    v = 24'(c.dc_upper_thresholds);
        jabd_pkg::REG_AC_BAND:     v = c.ac_band_limits;
        default:                   v = 24'(c.table_select);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= v;
      do @(posedge clk); while (!cfg_ready);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid <= 1'b0;
    regs = c;
  endtask

  task automatic drive_random(int count);
    int roll;
    logic [1:0] comp;
    logic b;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      comp = 2'($urandom_range(0, 3));
      b    = 1'($urandom_range(0, 1));
      if (roll < 2) begin
        send_item(jabd_pkg::KIND_RESTART, comp, b);
      end else if (roll < 4) begin
        send_item(KIND_UNUSED, comp, b);
      end else if (ph == jabd_pkg::PH_IDLE) begin
        if (roll < 7) begin
          send_item(jabd_pkg::KIND_DECISION, comp, b);
        end else begin
          blocks_started++;
          runaway = (blocks_started % 8 == 7);
          send_item(jabd_pkg::KIND_START, comp, b);
        end
      end else if (roll < 6) begin
        send_item(jabd_pkg::KIND_START, comp, b);
      end else begin
        send_item(jabd_pkg::KIND_DECISION, comp, pick_bit());
      end
    end
  endtask

  // Register extremes, a negative DC-only block, and items that find no block.
  task automatic test_register_extremes();
    jabd_pkg::cfg_t c;
    c = '{scan_start: 6'd0, scan_stop: 6'd0, point_shift: 4'd15, differential_mode: 1'b1,
          dc_lower_thresholds: 16'hFFFF, dc_upper_thresholds: 16'h0000,
          ac_band_limits: 24'hFFFFFF, table_select: 16'hFFFF};
    load_config(c);
    send_item(jabd_pkg::KIND_START, 2'd3, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd3, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_RESTART, 2'd2, 1'b1);
    send_item(KIND_UNUSED, 2'd1, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
  endtask

  // Zero DC, one AC coefficient, end of block; then an abandoned block and
  // a DC difference that goes through category and refinement bits.
  task automatic test_dc_and_ac();
    load_config(CFG_DEFAULT);
    send_item(jabd_pkg::KIND_START, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_START, 2'd1, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(KIND_UNUSED, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_START, 2'd2, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
  endtask

  // Empty scan, a zero run past the scan end, and a register change while a
  // block is in progress.
  task automatic test_scan_limits();
    jabd_pkg::cfg_t c;
    c = CFG_DEFAULT;
    c.scan_start = 6'd5;
    c.scan_stop  = 6'd3;
    load_config(c);
    send_item(jabd_pkg::KIND_START, 2'd0, 1'b1);
    c.scan_start = 6'd62;
    c.scan_stop  = 6'd63;
    load_config(c);
    send_item(jabd_pkg::KIND_START, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_START, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    c.table_select = 16'h000C;
    c.point_shift  = 4'd4;
    load_config(c);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b0);
    send_item(jabd_pkg::KIND_DECISION, 2'd0, 1'b1);
  endtask

  // The receiver holds off while items keep coming, so the block must stall
  // its input; then the sender waits for every result.
  task automatic test_backpressure();
    load_config(CFG_DEFAULT);
    idle_pct  = 0;
    sink_hold = 150;
    drive_random(30);
    drain_results();
  endtask

  task automatic test_random();
    jabd_pkg::cfg_t c;
    for (int seg = 0; seg < 12; seg++) begin
      c.scan_start = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
      c.scan_stop  = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(c.scan_start, 63))
                                                 : 6'($urandom_range(0, 63));
      c.point_shift         = 4'($urandom_range(0, 15));
      c.differential_mode   = 1'($urandom_range(0, 1));
      c.dc_lower_thresholds = 16'($urandom);
      c.dc_upper_thresholds = 16'($urandom);
      c.ac_band_limits      = 24'($urandom);
      c.table_select        = 16'($urandom);
      load_config(c);
      if (seg >= 10) idle_pct = 0;
      else idle_pct = (seg % 3 == 2) ? 0 : 25;
      drive_random(50);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold != 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_monitor
    jabd_pkg::res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.need_decision  = out_tuser[0];
      got.coef_valid     = out_tuser[1];
      got.context_is_ac  = out_tdata[0];
      got.context_table  = out_tdata[2:1];
      got.context_offset = out_tdata[10:3];
      got.coef_position  = out_tdata[16:11];
      got.coef_value     = out_tdata[33:17];
      got.sync_error     = out_tdata[34];
      got.block_done     = out_tlast;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = expected_results.pop_front();
        check_field("need_decision", got.need_decision, want.need_decision);
        check_field("context_is_ac", got.context_is_ac, want.context_is_ac);
        check_field("context_table", got.context_table, want.context_table);
        check_field("context_offset", got.context_offset, want.context_offset);
        check_field("coef_valid", got.coef_valid, want.coef_valid);
        check_field("coef_position", got.coef_position, want.coef_position);
        check_field("coef_value", got.coef_value, want.coef_value);
        check_field("block_done", got.block_done, want.block_done);
        check_field("sync_error", got.sync_error, want.sync_error);
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results pending",
               cycle_count, expected_results.size());
      $display("tb_jpeg_arith_block_debinarizer: errors");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_register_extremes();
    test_dc_and_ac();
    test_scan_limits();
    test_backpressure();
    test_random();
    drain_results();
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (err_count == 0) begin
      $display("tb_jpeg_arith_block_debinarizer: clean");
    end else begin
      $display("tb_jpeg_arith_block_debinarizer: errors");
    end
    $finish;
  end

endmodule
